### rtl/core/tiny_16bit_cpu_execute_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the tiny 16-bit CPU execute core.
// Both expect signals named clock and reset in the scope of use.
// ----------------------------------------------------------------------------
`ifndef TINY_16BIT_CPU_EXECUTE_CORE_DEFINES_SVH
`define TINY_16BIT_CPU_EXECUTE_CORE_DEFINES_SVH

// Concurrent assertion with a generic failure message.
`define TCX_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("tcx assertion failed");

// Concurrent assertion with a caller supplied failure message.
`define TCX_ASSERT_MSG(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

`endif

### rtl/core/tcx_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcx_pkg
// Shared types and constants of the tiny 16-bit CPU execute core.
// ----------------------------------------------------------------------------
package tcx_pkg;

   localparam int TCX_DATA_MEM_DEPTH = 256;
   localparam int TCX_ADDR_SPAN      = 256;
   localparam int TCX_NUM_REGS       = 8;
   localparam int TCX_REG_IDX_W      = 3;
   localparam int TCX_WORD_W         = 16;
   localparam int TCX_PC_W           = 8;

   typedef enum logic [3:0] {
      OP_MOV = 4'd0,
      OP_ADD = 4'd1,
      OP_SUB = 4'd2,
      OP_AND = 4'd3,
      OP_OR  = 4'd4,
      OP_SL  = 4'd5,
      OP_SR  = 4'd6,
      OP_SRA = 4'd7,
      OP_LDL = 4'd8,
      OP_LDH = 4'd9,
      OP_CMP = 4'd10,
      OP_JE  = 4'd11,
      OP_JMP = 4'd12,
      OP_LD  = 4'd13,
      OP_ST  = 4'd14,
      OP_HLT = 4'd15
   } op_type;

   typedef struct packed {
      logic [TCX_PC_W-1:0]      next_pc;
      logic                     halted;
      logic                     equal_flag;
      logic                     reg_write_valid;
      logic [TCX_REG_IDX_W-1:0] reg_write_index;
      logic [TCX_WORD_W-1:0]    reg_write_value;
      logic                     store_valid;
      logic [TCX_PC_W-1:0]      store_address;
      logic [TCX_WORD_W-1:0]    store_value;
   } ex_result_type;

endpackage

### rtl/core/tcx_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcx_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module tcx_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/tcx_mem_index.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcx_mem_index
// Reduces an 8-bit address field modulo the data memory depth.
// ----------------------------------------------------------------------------
module tcx_mem_index import tcx_pkg::*; #(
   parameter int DEPTH = TCX_DATA_MEM_DEPTH
) (
   input  logic [TCX_PC_W-1:0]      raw_addr,
   output logic [$clog2(DEPTH)-1:0] mem_idx
);

   localparam int MaxMult = TCX_ADDR_SPAN / DEPTH;

   logic [TCX_PC_W-1:0] base;
   logic [TCX_PC_W-1:0] diff;

   // The largest multiple of the depth not above the address is subtracted.
   always_comb begin
      base = '0;
      for (int k = 1; k <= MaxMult; k++) begin
         if (k * DEPTH < TCX_ADDR_SPAN) begin
            if (raw_addr >= TCX_PC_W'(k * DEPTH)) begin
               base = TCX_PC_W'(k * DEPTH);
            end
         end
      end
      diff = raw_addr - base;
   end

   assign mem_idx = diff[$clog2(DEPTH)-1:0];

endmodule

### rtl/core/tcx_exec.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcx_exec
// Decode and execute logic for one instruction word against its operands.
// ----------------------------------------------------------------------------
module tcx_exec import tcx_pkg::*; #(
   parameter int DEPTH = TCX_DATA_MEM_DEPTH
) (
   input  logic [TCX_WORD_W-1:0] instr,
   input  logic [TCX_WORD_W-1:0] opnd_a,
   input  logic [TCX_WORD_W-1:0] opnd_b,
   input  logic [TCX_WORD_W-1:0] mem_data,
   input  logic [TCX_PC_W-1:0]   pc,
   input  logic                  equal_flag,
   input  logic                  stopped,
   output ex_result_type         result
);

   op_type                   op;
   logic [TCX_PC_W-1:0]      imm;
   logic [$clog2(DEPTH)-1:0] st_idx;

   assign op  = op_type'(instr[14:11]);
   assign imm = instr[7:0];

   tcx_mem_index #(
      .DEPTH(DEPTH)
   ) u_st_index (
      .raw_addr(imm),
      .mem_idx (st_idx)
   );

   always_comb begin
      result                 = '0;
      result.next_pc         = pc;
      result.halted          = stopped;
      result.equal_flag      = equal_flag;
      result.reg_write_index = '0;
      if (!stopped) begin
         result.next_pc = pc + TCX_PC_W'(1);
         if (!instr[15]) begin
            case (op)
               OP_MOV: begin
                  result.reg_write_valid = 1'b1;
                  result.reg_write_value = opnd_b;
               end
               OP_ADD: begin
                  result.reg_write_valid = 1'b1;
                  result.reg_write_value = opnd_a + opnd_b;
               end
               OP_SUB: begin
                  result.reg_write_valid = 1'b1;
                  result.reg_write_value = opnd_a - opnd_b;
               end
               OP_AND: begin
                  result.reg_write_valid = 1'b1;
                  result.reg_write_value = opnd_a & opnd_b;
               end
               OP_OR: begin
                  result.reg_write_valid = 1'b1;
                  result.reg_write_value = opnd_a | opnd_b;
               end
               OP_SL: begin
                  result.reg_write_valid = 1'b1;
                  result.reg_write_value = {opnd_a[14:0], 1'b0};
               end
               OP_SR: begin
                  result.reg_write_valid = 1'b1;
                  result.reg_write_value = {1'b0, opnd_a[15:1]};
               end
               OP_SRA: begin
                  result.reg_write_valid = 1'b1;
                  result.reg_write_value = {opnd_a[15], opnd_a[15:1]};
               end
               OP_LDL: begin
                  result.reg_write_valid = 1'b1;
                  result.reg_write_value = {opnd_a[15:8], imm};
               end
               OP_LDH: begin
                  result.reg_write_valid = 1'b1;
                  result.reg_write_value = {imm, opnd_a[7:0]};
               end
               OP_CMP: begin
                  result.equal_flag = (opnd_a == opnd_b);
               end
               OP_JE: begin
                  if (equal_flag) begin
                     result.next_pc = imm;
                  end
               end
               OP_JMP: begin
                  result.next_pc = imm;
               end
               OP_LD: begin
                  result.reg_write_valid = 1'b1;
                  result.reg_write_value = mem_data;
               end
               OP_ST: begin
                  result.store_valid   = 1'b1;
                  result.store_address = TCX_PC_W'(st_idx);
                  result.store_value   = opnd_a;
               end
               OP_HLT: begin
                  result.halted = 1'b1;
               end
               default: begin
                  result.halted = stopped;
               end
            endcase
         end
      end
      if (result.reg_write_valid) begin
         result.reg_write_index = instr[10:8];
      end
   end

endmodule

### rtl/core/tiny_16bit_cpu_execute_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tiny_16bit_cpu_execute_core
// Executes one 16-bit instruction word per item for a small teaching CPU.
//
// The req_ channel carries one instruction word per item, fetched at the
// program counter that the previous result reported. The rsp_ channel returns
// one result per item: next pc, halted and equal flags, and the register or
// data memory write the instruction made.
// An accepted item is held in the execute stage and then in the result
// register on rsp_. One item is accepted every cycle while req_ready is
// high, set by the single execute stage, which reads the register file and
// data memory ahead and forwards the most recent write around the RAMs.
// Reset clears pc, flags and halted mark and the per-entry written bits of
// the register file and data memory; an entry not yet written reads as zero,
// so no clearing pass is needed and items are taken right after reset.
// When the receiver stalls, the result register holds its item, the execute
// stage holds one more, and req_ready falls once both are full.
// ----------------------------------------------------------------------------
module tiny_16bit_cpu_execute_core import tcx_pkg::*; #(
   parameter int DATA_MEM_DEPTH = TCX_DATA_MEM_DEPTH
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [TCX_WORD_W-1:0]    req_instr_word,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [TCX_PC_W-1:0]      rsp_next_pc,
   output logic                     rsp_halted,
   output logic                     rsp_equal_flag,
   output logic                     rsp_reg_write_valid,
   output logic [TCX_REG_IDX_W-1:0] rsp_reg_write_index,
   output logic [TCX_WORD_W-1:0]    rsp_reg_write_value,
   output logic                     rsp_store_valid,
   output logic [TCX_PC_W-1:0]      rsp_store_address,
   output logic [TCX_WORD_W-1:0]    rsp_store_value
);

   localparam int AddrW = $clog2(DATA_MEM_DEPTH);

   logic accept;
   logic advance;
   logic commit;

   logic [TCX_REG_IDX_W-1:0] rd_ra;
   logic [TCX_REG_IDX_W-1:0] rd_rb;
   logic [AddrW-1:0]         rd_midx;

   logic                     ex_valid_ff;
   logic [TCX_WORD_W-1:0]    ex_instr_ff;
   logic                     a_known_ff;
   logic                     b_known_ff;
   logic                     m_known_ff;

   logic [TCX_NUM_REGS-1:0]   reg_written_ff;
   logic [DATA_MEM_DEPTH-1:0] mem_written_ff;

   logic                     lw_valid_ff;
   logic [TCX_REG_IDX_W-1:0] lw_idx_ff;
   logic [TCX_WORD_W-1:0]    lw_val_ff;
   logic                     ls_valid_ff;
   logic [AddrW-1:0]         ls_addr_ff;
   logic [TCX_WORD_W-1:0]    ls_val_ff;

   logic [TCX_PC_W-1:0] pc_ff;
   logic                eq_ff;
   logic                halted_ff;

   logic          rsp_valid_ff;
   ex_result_type rsp_data_ff;

   logic [TCX_WORD_W-1:0] ram_a;
   logic [TCX_WORD_W-1:0] ram_b;
   logic [TCX_WORD_W-1:0] ram_m;
   logic [TCX_WORD_W-1:0] opnd_a;
   logic [TCX_WORD_W-1:0] opnd_b;
   logic [TCX_WORD_W-1:0] mem_data;
   logic [AddrW-1:0]      ex_midx;
   ex_result_type         ex_result;
   logic [AddrW-1:0]      st_idx;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = !ex_valid_ff || advance;
   assign accept    = req_valid && req_ready;
   assign commit    = ex_valid_ff && advance;

   assign rd_ra = req_instr_word[10:8];
   assign rd_rb = req_instr_word[7:5];

   tcx_mem_index #(
      .DEPTH(DATA_MEM_DEPTH)
   ) u_rd_index (
      .raw_addr(req_instr_word[7:0]),
      .mem_idx (rd_midx)
   );

   tcx_mem_index #(
      .DEPTH(DATA_MEM_DEPTH)
   ) u_ex_index (
      .raw_addr(ex_instr_ff[7:0]),
      .mem_idx (ex_midx)
   );

   assign st_idx = ex_result.store_address[AddrW-1:0];

   tcx_ram #(
      .WIDTH(TCX_WORD_W),
      .DEPTH(TCX_NUM_REGS)
   ) u_regs_a (
      .clock  (clock),
      .wr_en  (commit && ex_result.reg_write_valid),
      .wr_addr(ex_result.reg_write_index),
      .wr_data(ex_result.reg_write_value),
      .rd_en  (accept),
      .rd_addr(rd_ra),
      .rd_data(ram_a)
   );

   tcx_ram #(
      .WIDTH(TCX_WORD_W),
      .DEPTH(TCX_NUM_REGS)
   ) u_regs_b (
      .clock  (clock),
      .wr_en  (commit && ex_result.reg_write_valid),
      .wr_addr(ex_result.reg_write_index),
      .wr_data(ex_result.reg_write_value),
      .rd_en  (accept),
      .rd_addr(rd_rb),
      .rd_data(ram_b)
   );

   tcx_ram #(
      .WIDTH(TCX_WORD_W),
      .DEPTH(DATA_MEM_DEPTH)
   ) u_dmem (
      .clock  (clock),
      .wr_en  (commit && ex_result.store_valid),
      .wr_addr(st_idx),
      .wr_data(ex_result.store_value),
      .rd_en  (accept),
      .rd_addr(rd_midx),
      .rd_data(ram_m)
   );

   // The last write always holds the newest value of its entry, which covers
   // a write made at the same edge as the read.
   always_comb begin
      if (lw_valid_ff && lw_idx_ff == ex_instr_ff[10:8]) begin
         opnd_a = lw_val_ff;
      end else begin
         opnd_a = a_known_ff ? ram_a : '0;
      end
      if (lw_valid_ff && lw_idx_ff == ex_instr_ff[7:5]) begin
         opnd_b = lw_val_ff;
      end else begin
         opnd_b = b_known_ff ? ram_b : '0;
      end
      if (ls_valid_ff && ls_addr_ff == ex_midx) begin
         mem_data = ls_val_ff;
      end else begin
         mem_data = m_known_ff ? ram_m : '0;
      end
   end

   tcx_exec #(
      .DEPTH(DATA_MEM_DEPTH)
   ) u_exec (
      .instr     (ex_instr_ff),
      .opnd_a    (opnd_a),
      .opnd_b    (opnd_b),
      .mem_data  (mem_data),
      .pc        (pc_ff),
      .equal_flag(eq_ff),
      .stopped   (halted_ff),
      .result    (ex_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         ex_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         reg_written_ff <= '0;
         mem_written_ff <= '0;
         lw_valid_ff    <= 1'b0;
         ls_valid_ff    <= 1'b0;
         pc_ff          <= '0;
         eq_ff          <= 1'b0;
         halted_ff      <= 1'b0;
      end else begin
         if (req_ready) begin
            ex_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= ex_valid_ff;
         end
         if (commit) begin
            pc_ff     <= ex_result.next_pc;
            eq_ff     <= ex_result.equal_flag;
            halted_ff <= ex_result.halted;
            if (ex_result.reg_write_valid) begin
               reg_written_ff[ex_result.reg_write_index] <= 1'b1;
               lw_valid_ff <= 1'b1;
            end
            if (ex_result.store_valid) begin
               mem_written_ff[st_idx] <= 1'b1;
               ls_valid_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         ex_instr_ff <= req_instr_word;
         a_known_ff  <= reg_written_ff[rd_ra];
         b_known_ff  <= reg_written_ff[rd_rb];
         m_known_ff  <= mem_written_ff[rd_midx];
      end
      if (commit) begin
         rsp_data_ff <= ex_result;
         if (ex_result.reg_write_valid) begin
            lw_idx_ff <= ex_result.reg_write_index;
            lw_val_ff <= ex_result.reg_write_value;
         end
         if (ex_result.store_valid) begin
            ls_addr_ff <= st_idx;
            ls_val_ff  <= ex_result.store_value;
         end
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_next_pc         = rsp_data_ff.next_pc;
   assign rsp_halted          = rsp_data_ff.halted;
   assign rsp_equal_flag      = rsp_data_ff.equal_flag;
   assign rsp_reg_write_valid = rsp_data_ff.reg_write_valid;
   assign rsp_reg_write_index = rsp_data_ff.reg_write_index;
   assign rsp_reg_write_value = rsp_data_ff.reg_write_value;
   assign rsp_store_valid     = rsp_data_ff.store_valid;
   assign rsp_store_address   = rsp_data_ff.store_address;
   assign rsp_store_value     = rsp_data_ff.store_value;

endmodule

### rtl/core/tcx_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcx_checker
// Port level checks of the tiny 16-bit CPU execute core, bound to the top.
// ----------------------------------------------------------------------------
`include "tiny_16bit_cpu_execute_core_defines.svh"

module tcx_checker import tcx_pkg::*; (
   input logic                     clock,
   input logic                     reset,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic [TCX_PC_W-1:0]      rsp_next_pc,
   input logic                     rsp_halted,
   input logic                     rsp_equal_flag,
   input logic                     rsp_reg_write_valid,
   input logic [TCX_REG_IDX_W-1:0] rsp_reg_write_index,
   input logic [TCX_WORD_W-1:0]    rsp_reg_write_value,
   input logic                     rsp_store_valid,
   input logic [TCX_PC_W-1:0]      rsp_store_address,
   input logic [TCX_WORD_W-1:0]    rsp_store_value
);

   logic seen_halt_ff;

   // Set once an item reporting the halted mark has been delivered.
   always_ff @(posedge clock) begin
      if (reset) begin
         seen_halt_ff <= 1'b0;
      end else if (rsp_valid && rsp_ready && rsp_halted) begin
         seen_halt_ff <= 1'b1;
      end
   end

   `TCX_ASSERT_MSG(a_halt_sticky, rsp_valid && seen_halt_ff |-> rsp_halted,
                   "halted mark cleared after a halt")

   `TCX_ASSERT_MSG(a_no_write_after_halt,
                   rsp_valid && seen_halt_ff |-> !rsp_reg_write_valid && !rsp_store_valid,
                   "write reported after a halt")

   `TCX_ASSERT(a_single_write, rsp_valid |-> !(rsp_reg_write_valid && rsp_store_valid))

   `TCX_ASSERT(a_idle_fields_zero,
               rsp_valid && !rsp_store_valid |->
               rsp_store_address == 8'd0 && rsp_store_value == 16'd0)

   `TCX_ASSERT(a_rsp_hold,
               rsp_valid && !rsp_ready |=> rsp_valid &&
               $stable({rsp_next_pc, rsp_halted, rsp_equal_flag, rsp_reg_write_valid,
                        rsp_reg_write_index, rsp_reg_write_value, rsp_store_valid,
                        rsp_store_address, rsp_store_value}))

endmodule

bind tiny_16bit_cpu_execute_core tcx_checker u_tcx_checker (.*);
